// ----- rtl/gaussian_noise_pixel_adder_core_assert.svh -----
// Assertion shorthands shared by gnpa_seq and the core top level.
`ifndef GAUSSIAN_NOISE_PIXEL_ADDER_CORE_ASSERT_SVH
`define GAUSSIAN_NOISE_PIXEL_ADDER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GNPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GNPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gnpa_pkg.sv -----
package gnpa_pkg;

    localparam int unsigned PIX_W     = 16;
    localparam int unsigned SIGMA_W   = 24;
    localparam int unsigned SEED_W    = 31;
    localparam int unsigned SUM_W     = 31;
    localparam int unsigned MAG_W     = 30;
    localparam int unsigned PROD_W    = 54;
    localparam int unsigned SCALE_W   = 20;
    localparam int unsigned TOTAL_W   = 22;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned PC_W      = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 31;

    localparam logic [SEED_W-1:0]  LCG_MUL       = 31'd1103515245;
    localparam logic [SEED_W-1:0]  LCG_ADD       = 31'd12345;
    localparam logic signed [31:0] CENTRE_OFFSET = 32'sd805306368;

    localparam logic [CNT_W-1:0] GEN_STEPS = 4'd12;
    localparam logic [CNT_W-1:0] LOOP_LAST = 4'd11;

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 24'd256;
    localparam logic [SEED_W-1:0]  SEED_RESET  = 31'd1;

    localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'b1;

    localparam logic signed [TOTAL_W-1:0] PIX_MAX = 22'sd32767;
    localparam logic signed [TOTAL_W-1:0] PIX_MIN = -22'sd32768;

    // Program steps
    localparam logic [PC_W-1:0] PC_WAIT = 3'd0;
    localparam logic [PC_W-1:0] PC_LOOP = 3'd1;
    localparam logic [PC_W-1:0] PC_ADD  = 3'd2;
    localparam logic [PC_W-1:0] PC_MUL  = 3'd3;
    localparam logic [PC_W-1:0] PC_OUT  = 3'd4;

    typedef enum logic [1:0] {
        J_NEVER,
        J_ALWAYS,
        J_LOOP
    } t_jump;

    typedef struct packed {
        logic accept;
        logic advance;
        logic add;
        logic mul;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        t_ctrl           ctrl;
        t_jump           jump;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             clipped;
        logic             last;
    } t_result;

    // Control store: one word per program step.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_WAIT: begin
                w.ctrl.accept  = 1'b1;
                w.ctrl.advance = 1'b1;
                w.jump         = J_NEVER;
            end
            PC_LOOP: begin
                w.ctrl.advance = 1'b1;
                w.ctrl.add     = 1'b1;
                w.jump         = J_LOOP;
                w.target       = PC_LOOP;
            end
            PC_ADD: begin
                w.ctrl.add = 1'b1;
                w.jump     = J_NEVER;
            end
            PC_MUL: begin
                w.ctrl.mul = 1'b1;
                w.jump     = J_NEVER;
            end
            PC_OUT: begin
                w.ctrl.emit = 1'b1;
                w.jump      = J_ALWAYS;
                w.target    = PC_WAIT;
            end
            default: begin
                w.jump   = J_ALWAYS;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/gnpa_seq.sv -----
`include "gaussian_noise_pixel_adder_core_assert.svh"

module gnpa_seq
    import gnpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_uword           w_word;
    logic             w_hold;

    assign w_word     = ucode(r_pc);
    // Hold off requests while reset is applied.
    assign o_in_ready = w_word.ctrl.accept && i_rst_n;

    // Stall on a missing request or a full output slot; no side effects while stalled.
    assign w_hold = (w_word.ctrl.accept && !i_in_valid) ||
                    (w_word.ctrl.emit && !i_out_free);
    assign o_ctrl = w_hold ? '0 : w_word.ctrl;

    always_comb begin
        n_pc  = r_pc;
        n_cnt = r_cnt;
        if (!w_hold) begin
            case (w_word.jump)
                J_ALWAYS: n_pc = w_word.target;
                J_LOOP:   n_pc = (r_cnt != LOOP_LAST) ? w_word.target : r_pc + 3'd1;
                J_NEVER:  n_pc = r_pc + 3'd1;
                default:  n_pc = PC_WAIT;
            endcase
            if (w_word.ctrl.accept) begin
                n_cnt = 4'd1;
            end else if (w_word.ctrl.advance) begin
                n_cnt = r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    `GNPA_ASSERT_NEXT(a_cnt_start, o_ctrl.accept, r_cnt == 4'd1, "step count not restarted on request")
    `GNPA_ASSERT_IMP(a_mul_after_steps, o_ctrl.mul, r_cnt == GEN_STEPS, "scale before twelve steps")
    `GNPA_ASSERT_IMP(a_emit_order, o_ctrl.emit, $past(r_pc) == PC_MUL || $past(r_pc) == PC_OUT, "emit out of order")

endmodule

// ----- rtl/gnpa_dp.sv -----
module gnpa_dp
    import gnpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_last,
    output t_result              o_result
);

    logic [SIGMA_W-1:0]         r_sigma;
    logic [SEED_W-1:0]          r_state;
    logic [SUM_W-1:0]           r_sum;
    logic [PIX_W-1:0]           r_pix;
    logic                       r_last;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg;

    logic [SEED_W-1:0]          w_lcg_mul;
    logic [SEED_W-1:0]          w_lcg_next;
    logic signed [31:0]         w_centred;
    logic [MAG_W-1:0]           w_mag;
    logic [SCALE_W-1:0]         w_scaled;
    logic signed [TOTAL_W-1:0]  w_noise;
    logic signed [TOTAL_W-1:0]  w_total;

    // LCG step, modulo 2^31
    assign w_lcg_mul  = r_state * LCG_MUL;
    assign w_lcg_next = w_lcg_mul + LCG_ADD;

    assign w_centred = $signed({1'b0, r_sum}) - CENTRE_OFFSET;
    assign w_mag     = w_centred[31] ? MAG_W'(-w_centred) : w_centred[MAG_W-1:0];

    // Round half away from zero on the magnitude, then restore sign.
    assign w_scaled = {1'b0, r_prod[PROD_W-1:35]} + SCALE_W'(r_prod[34]);
    assign w_noise  = r_neg ? -$signed({2'b00, w_scaled}) : $signed({2'b00, w_scaled});
    assign w_total  = $signed({{(TOTAL_W-PIX_W){r_pix[PIX_W-1]}}, r_pix}) + w_noise;

    always_comb begin
        o_result.last    = r_last;
        o_result.clipped = 1'b0;
        o_result.pixel   = w_total[PIX_W-1:0];
        if (w_total > PIX_MAX) begin
            o_result.pixel   = PIX_MAX[PIX_W-1:0];
            o_result.clipped = 1'b1;
        end else if (w_total < PIX_MIN) begin
            o_result.pixel   = PIX_MIN[PIX_W-1:0];
            o_result.clipped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= SIGMA_RESET;
            r_state <= SEED_RESET;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_SIGMA) begin
                r_sigma <= i_cfg_data[SIGMA_W-1:0];
            end
            // Seed write reloads the generator over any step.
            if (i_cfg_we && i_cfg_idx == REG_SEED) begin
                r_state <= i_cfg_data[SEED_W-1:0];
            end else if (i_ctrl.advance) begin
                r_state <= w_lcg_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_pix  <= i_pixel;
            r_last <= i_last;
            r_sum  <= '0;
        end else if (i_ctrl.add) begin
            r_sum <= r_sum + {4'b0000, r_state[SEED_W-1:4]};
        end
        if (i_ctrl.mul) begin
            r_prod <= PROD_W'(w_mag * r_sigma);
            r_neg  <= w_centred[31];
        end
    end

endmodule

// ----- rtl/gaussian_noise_pixel_adder_core.sv -----
// Adds approximately Gaussian noise to a stream of signed 16-bit pixels. For each pixel the
// sequencer takes the request and makes the first generator step, makes eleven more steps
// through the single 31-bit LCG multiplier, each adding the previous state into the sum,
// adds the last state, makes one scaling multiply by sigma, then rounds, adds and
// saturates into the output register. A result that waits for the receiver holds the
// sequencer in that last step; the next pixel is taken while the previous result waits in
// the output register. Register 0 holds sigma (unsigned, 8 fraction bits, reset 1.0);
// register 1 holds the seed, and writing it reloads the generator state at once.
// Write configuration only while no pixel is in flight.
`include "gaussian_noise_pixel_adder_core_assert.svh"

module gaussian_noise_pixel_adder_core
    import gnpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // [15:0] pixel_in
    input  logic                 i_s_axis_tlast,   // last_in_image
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [15:0] pixel_out
    output logic [0:0]           o_m_axis_tuser,   // [0] clipped
    output logic                 o_m_axis_tlast    // last_out
);

    t_ctrl   w_ctrl;
    t_result w_result;
    logic    w_out_free;
    logic    r_out_valid;
    t_result r_out;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    gnpa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    gnpa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pixel    (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out.pixel;
    assign o_m_axis_tuser[0] = r_out.clipped;
    assign o_m_axis_tlast    = r_out.last;

    `GNPA_ASSERT_IMP(a_load_not_taking, w_ctrl.emit, !o_s_axis_tready, "result load while taking request")
    `GNPA_ASSERT_NEXT(a_load_shows, w_ctrl.emit, o_m_axis_tvalid, "loaded result not presented")

endmodule
